// ----- rtl/sha512_pkg.sv -----
package sha512_pkg;

    localparam int unsigned WordW     = 64;
    localparam int unsigned HashDepth = 8;
    localparam int unsigned BlkDepth  = 16;
    localparam int unsigned Rounds    = 80;

    typedef struct packed {
        logic [63:0] message_word;
        logic [3:0]  valid_bytes;
        logic        last_word;
    } t_in_item;

    typedef struct packed {
        logic [63:0] digest_word;
        logic        digest_last;
    } t_out_item;

    localparam logic [63:0] PadWord = 64'h8000000000000000;

    function automatic logic [63:0] iv(input logic [2:0] i);
        logic [63:0] r;
        begin
            case (i)
                3'd0:    r = 64'h6a09e667f3bcc908;
                3'd1:    r = 64'hbb67ae8584caa73b;
                3'd2:    r = 64'h3c6ef372fe94f82b;
                3'd3:    r = 64'ha54ff53a5f1d36f1;
                3'd4:    r = 64'h510e527fade682d1;
                3'd5:    r = 64'h9b05688c2b3e6c1f;
                3'd6:    r = 64'h1f83d9abfb41bd6b;
                default: r = 64'h5be0cd19137e2179;
            endcase
            return r;
        end
    endfunction

    function automatic logic [63:0] rk(input logic [6:0] i);
        logic [63:0] r;
        begin
            case (i)
                7'd0: r = 64'h428a2f98d728ae22; 7'd1: r = 64'h7137449123ef65cd;
                7'd2: r = 64'hb5c0fbcfec4d3b2f; 7'd3: r = 64'he9b5dba58189dbbc;
                7'd4: r = 64'h3956c25bf348b538; 7'd5: r = 64'h59f111f1b605d019;
                7'd6: r = 64'h923f82a4af194f9b; 7'd7: r = 64'hab1c5ed5da6d8118;
                7'd8: r = 64'hd807aa98a3030242; 7'd9: r = 64'h12835b0145706fbe;
                7'd10: r = 64'h243185be4ee4b28c; 7'd11: r = 64'h550c7dc3d5ffb4e2;
                7'd12: r = 64'h72be5d74f27b896f; 7'd13: r = 64'h80deb1fe3b1696b1;
                7'd14: r = 64'h9bdc06a725c71235; 7'd15: r = 64'hc19bf174cf692694;
                7'd16: r = 64'he49b69c19ef14ad2; 7'd17: r = 64'hefbe4786384f25e3;
                7'd18: r = 64'h0fc19dc68b8cd5b5; 7'd19: r = 64'h240ca1cc77ac9c65;
                7'd20: r = 64'h2de92c6f592b0275; 7'd21: r = 64'h4a7484aa6ea6e483;
                7'd22: r = 64'h5cb0a9dcbd41fbd4; 7'd23: r = 64'h76f988da831153b5;
                7'd24: r = 64'h983e5152ee66dfab; 7'd25: r = 64'ha831c66d2db43210;
                7'd26: r = 64'hb00327c898fb213f; 7'd27: r = 64'hbf597fc7beef0ee4;
                7'd28: r = 64'hc6e00bf33da88fc2; 7'd29: r = 64'hd5a79147930aa725;
                7'd30: r = 64'h06ca6351e003826f; 7'd31: r = 64'h142929670a0e6e70;
                7'd32: r = 64'h27b70a8546d22ffc; 7'd33: r = 64'h2e1b21385c26c926;
                7'd34: r = 64'h4d2c6dfc5ac42aed; 7'd35: r = 64'h53380d139d95b3df;
                7'd36: r = 64'h650a73548baf63de; 7'd37: r = 64'h766a0abb3c77b2a8;
                7'd38: r = 64'h81c2c92e47edaee6; 7'd39: r = 64'h92722c851482353b;
                7'd40: r = 64'ha2bfe8a14cf10364; 7'd41: r = 64'ha81a664bbc423001;
                7'd42: r = 64'hc24b8b70d0f89791; 7'd43: r = 64'hc76c51a30654be30;
                7'd44: r = 64'hd192e819d6ef5218; 7'd45: r = 64'hd69906245565a910;
                7'd46: r = 64'hf40e35855771202a; 7'd47: r = 64'h106aa07032bbd1b8;
                7'd48: r = 64'h19a4c116b8d2d0c8; 7'd49: r = 64'h1e376c085141ab53;
                7'd50: r = 64'h2748774cdf8eeb99; 7'd51: r = 64'h34b0bcb5e19b48a8;
                7'd52: r = 64'h391c0cb3c5c95a63; 7'd53: r = 64'h4ed8aa4ae3418acb;
                7'd54: r = 64'h5b9cca4f7763e373; 7'd55: r = 64'h682e6ff3d6b2b8a3;
                7'd56: r = 64'h748f82ee5defb2fc; 7'd57: r = 64'h78a5636f43172f60;
                7'd58: r = 64'h84c87814a1f0ab72; 7'd59: r = 64'h8cc702081a6439ec;
                7'd60: r = 64'h90befffa23631e28; 7'd61: r = 64'ha4506cebde82bde9;
                7'd62: r = 64'hbef9a3f7b2c67915; 7'd63: r = 64'hc67178f2e372532b;
                7'd64: r = 64'hca273eceea26619c; 7'd65: r = 64'hd186b8c721c0c207;
                7'd66: r = 64'heada7dd6cde0eb1e; 7'd67: r = 64'hf57d4f7fee6ed178;
                7'd68: r = 64'h06f067aa72176fba; 7'd69: r = 64'h0a637dc5a2c898a6;
                7'd70: r = 64'h113f9804bef90dae; 7'd71: r = 64'h1b710b35131c471b;
                7'd72: r = 64'h28db77f523047d84; 7'd73: r = 64'h32caab7b40c72493;
                7'd74: r = 64'h3c9ebe0a15c9bebc; 7'd75: r = 64'h431d67c49c100d4c;
                7'd76: r = 64'h4cc5d4becb3e42b6; 7'd77: r = 64'h597f299cfc657e2a;
                7'd78: r = 64'h5fcb6fab3ad6faec;
                default: r = 64'h6c44198c4a475817;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- rtl/sha512_message_hasher_unit.sv -----
// channel | dir | valid    | stall    | payload
// in      | in  | i_valid  | o_stall  | i_data (t_in_item)
// out     | out | o_valid  | i_stall  | o_data (t_out_item)
// a non-last word is stored in the block; when it fills a block, 80 rounds run on one
// shared round unit, then the working state is folded into the hash
// a last word pushes padding one word a cycle, at most one extra block, then 8 digest words
// i_stall holds the digest word on the port; o_stall is high whenever the sequencer is busy
// synchronous active-low reset restores the initial hash, zero length and slot
module sha512_message_hasher_unit
    import sha512_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PAD   = 6'b000010,
        S_ROUND = 6'b000100,
        S_FOLD  = 6'b001000,
        S_OUT   = 6'b010000,
        S_FILL  = 6'b100000
    } t_state;

    t_state      r_state, n_state;
    logic [63:0] r_hash [HashDepth];
    logic [63:0] r_w    [BlkDepth];
    logic [63:0] r_v    [HashDepth];
    logic [63:0] r_len;
    logic [3:0]  r_slot;
    logic [6:0]  r_round;
    logic [2:0]  r_oidx;
    logic        r_final;
    logic        r_pad8;
    logic        r_fill_pending;
    logic        r_wrap;

    logic [63:0] a, e, s0, s1, ch, mj, t1, t2, kw, wp, wq, g0, g1, wn;
    logic [63:0] in_word, keep, padb;
    logic [3:0]  nb;
    logic        acc, push, push_last;
    logic [63:0] push_val;

    assign acc = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign nb = (i_data.valid_bytes > 4'd8) ? 4'd8 : i_data.valid_bytes;

    always_comb begin
        keep = (nb == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> {nb[3:0], 3'b000});
        padb = (nb == 4'd8) ? 64'd0 : (64'h80 << (7'd56 - {nb[3:0], 3'b000}));
        in_word = i_data.last_word ? ((i_data.message_word & keep) | padb)
                                   : i_data.message_word;
    end

    // round unit, schedule kept in a 16-word rolling window
    always_comb begin
        a  = r_v[0];
        e  = r_v[4];
        s1 = {e[13:0], e[63:14]} ^ {e[17:0], e[63:18]} ^ {e[40:0], e[63:41]};
        ch = (e & r_v[5]) ^ (~e & r_v[6]);
        kw = rk(r_round) + r_w[0];
        t1 = r_v[7] + s1 + ch + kw;
        s0 = {a[27:0], a[63:28]} ^ {a[33:0], a[63:34]} ^ {a[38:0], a[63:39]};
        mj = (a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2 = s0 + mj;
        wp = r_w[1];
        wq = r_w[14];
        g0 = {wp[0], wp[63:1]} ^ {wp[7:0], wp[63:8]} ^ (wp >> 7);
        g1 = {wq[18:0], wq[63:19]} ^ {wq[60:0], wq[63:61]} ^ (wq >> 6);
        wn = r_w[0] + g0 + r_w[9] + g1;
    end

    // word pushes into the block buffer, and next-state selection
    always_comb begin
        push = 1'b0;
        push_val = 64'd0;
        push_last = 1'b0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    push = 1'b1;
                    push_val = in_word;
                    if (i_data.last_word) begin
                        n_state = (r_slot == 4'd15) ? S_ROUND : S_PAD;
                    end else if (r_slot == 4'd15) begin
                        n_state = S_ROUND;
                    end
                end
            end
            S_PAD: begin
                push = 1'b1;
                if (r_pad8) begin
                    push_val = PadWord;
                end else if (r_slot == 4'd15 && !r_wrap) begin
                    push_val = r_len;
                    push_last = 1'b1;
                end
                if (r_slot == 4'd15) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                if (r_round == 7'(Rounds - 1)) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                n_state = r_final ? S_OUT : (r_fill_pending ? S_PAD : S_IDLE);
            end
            S_OUT: begin
                if (!i_stall && r_oidx == 3'd7) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len <= 64'd0;
            r_slot <= 4'd0;
            r_round <= 7'd0;
            r_oidx <= 3'd0;
            r_final <= 1'b0;
            r_pad8 <= 1'b0;
            r_fill_pending <= 1'b0;
            r_wrap <= 1'b0;
            for (int i = 0; i < HashDepth; i++) r_hash[i] <= iv(3'(i));
        end else begin
            r_state <= n_state;
            if (push) begin
                r_w[r_slot] <= push_val;
                r_slot <= r_slot + 4'd1;
                if (r_state == S_PAD && r_pad8) r_pad8 <= 1'b0;
                // padding byte in one of the last two slots pushes the length to a new block
                if (r_state == S_PAD && r_wrap && r_slot == 4'd15) r_wrap <= 1'b0;
                if (r_slot == 4'd14 && (r_state == S_PAD ? r_pad8
                                        : (i_data.last_word && nb != 4'd8))) begin
                    r_wrap <= 1'b1;
                end
                if (push_last) begin
                    r_final <= 1'b1;
                    r_fill_pending <= 1'b0;
                end
            end
            if (r_state == S_IDLE && acc) begin
                r_len <= r_len + (i_data.last_word ? {57'd0, nb, 3'b000} : 64'd64);
                r_pad8 <= i_data.last_word && nb == 4'd8;
                r_fill_pending <= i_data.last_word;
            end
            if (r_state == S_IDLE && n_state == S_ROUND || r_state == S_PAD
                && n_state == S_ROUND) begin
                for (int i = 0; i < HashDepth; i++) r_v[i] <= r_hash[i];
                r_round <= 7'd0;
            end
            if (r_state == S_ROUND) begin
                for (int i = 1; i < HashDepth; i++) begin
                    if (i != 4) r_v[i] <= r_v[i-1];
                end
                r_v[0] <= t1 + t2;
                r_v[4] <= r_v[3] + t1;
                for (int i = 0; i < BlkDepth - 1; i++) r_w[i] <= r_w[i+1];
                r_w[BlkDepth-1] <= wn;
                r_round <= r_round + 7'd1;
            end
            if (r_state == S_FOLD) begin
                for (int i = 0; i < HashDepth; i++) r_hash[i] <= r_hash[i] + r_v[i];
                r_round <= 7'd0;
                r_oidx <= 3'd0;
            end
            if (r_state == S_OUT && !i_stall) begin
                r_oidx <= r_oidx + 3'd1;
            end
            if (r_state == S_FILL) begin
                for (int i = 0; i < HashDepth; i++) r_hash[i] <= iv(3'(i));
                r_len <= 64'd0;
                r_slot <= 4'd0;
                r_final <= 1'b0;
                r_pad8 <= 1'b0;
            end
        end
    end

    assign o_valid = (r_state == S_OUT);
    assign o_data.digest_word = r_hash[r_oidx];
    assign o_data.digest_last = (r_oidx == 3'd7);

    a_busy_no_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("accept while busy");
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_round < 7'(Rounds))) else $error("round overrun");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(r_oidx))) else $error("digest moved");
    a_fill_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_data.digest_last) |=> (r_state == S_FILL))
        else $error("no reset after digest");

endmodule

// ----- test/sha512_message_hasher_unit_tb.sv -----
`timescale 1ns / 1ps

module sha512_message_hasher_unit_tb;
    import sha512_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_data;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_data;

    sha512_message_hasher_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    localparam logic [63:0] K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam logic [63:0] H0 [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    typedef struct {
        t_in_item    item;
        logic        known;
        logic [63:0] first_word;
    } t_vector;

    // digest of the empty message, first word
    localparam logic [63:0] EmptyH0 = 64'hcf83e1357eefb8bd;

    logic [63:0] chain [8];
    logic [63:0] blk [16];
    logic [63:0] msg_bits;
    int unsigned slot;
    t_out_item   digest_q [$];
    logic [63:0] known_q [$];
    logic        known_flag_q [$];

    int errors;
    int cycles;
    int sent;
    logic sending;

    function automatic logic [63:0] ror(logic [63:0] v, int n);
        return (v >> n) | (v << (64 - n));
    endfunction

    task automatic compress();
        logic [63:0] w [80];
        logic [63:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++) w[i] = blk[i];
        for (int i = 16; i < 80; i++)
            w[i] = w[i-16] + (ror(w[i-15], 1) ^ ror(w[i-15], 8) ^ (w[i-15] >> 7))
                 + w[i-7] + (ror(w[i-2], 19) ^ ror(w[i-2], 61) ^ (w[i-2] >> 6));
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
        for (int r = 0; r < 80; r++) begin
            t1 = h + (ror(e, 14) ^ ror(e, 18) ^ ror(e, 41)) + ((e & f) ^ (~e & g)) + K[r] + w[r];
            t2 = (ror(a, 28) ^ ror(a, 34) ^ ror(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endtask

    task automatic store_word(logic [63:0] w);
        blk[slot] = w;
        slot = (slot + 1) % 16;
        if (slot == 0) compress();
    endtask

    task automatic hash_word(t_in_item it, logic known, logic [63:0] kw);
        int unsigned n;
        logic [63:0] keep, pad;
        t_out_item r;
        if (!it.last_word) begin
            msg_bits += 64;
            store_word(it.message_word);
            return;
        end
        n = (it.valid_bytes > 8) ? 8 : it.valid_bytes;
        msg_bits += n * 8;
        if (n == 8) begin
            store_word(it.message_word);
            store_word(PadWord);
        end else begin
            keep = (n == 0) ? 64'd0 : ~64'd0 << (64 - 8 * n);
            pad = 64'h80 << (56 - 8 * n);
            store_word((it.message_word & keep) | pad);
        end
        while (slot != 14) store_word(64'd0);
        store_word(64'd0);
        store_word(msg_bits);
        for (int i = 0; i < 8; i++) begin
            r.digest_word = chain[i];
            r.digest_last = (i == 7);
            digest_q = {digest_q, r};
            known_flag_q = {known_flag_q, known && i == 0};
            known_q = {known_q, kw};
        end
        chain = H0;
        msg_bits = 0;
        slot = 0;
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    endtask

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: random stalls, check on each accepted transaction
    always @(posedge i_clk) begin
        t_out_item want;
        logic kf;
        logic [63:0] kw;
        if (i_rst_n && o_valid && !i_stall) begin
            if (digest_q.size() == 0) begin
                report("unexpected transaction", o_data.digest_word, 64'd0);
            end else begin
                want = digest_q.pop_front();
                kf = known_flag_q.pop_front();
                kw = known_q.pop_front();
                if (o_data.digest_word !== want.digest_word)
                    report("digest_word", o_data.digest_word, want.digest_word);
                if (kf && o_data.digest_word !== kw)
                    report("digest_word vs known", o_data.digest_word, kw);
                if (o_data.digest_last !== want.digest_last)
                    report("digest_last", o_data.digest_last, want.digest_last);
            end
        end
        if (!sending && cycles % 4000 > 3000) i_stall <= 1'b0;
        else if ($urandom_range(0, 19) == 0) i_stall <= 1'b1;
        else if ($urandom_range(0, 99) < (i_stall ? 30 : 70)) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(0, 3) == 0);
    end

    task automatic send(t_in_item it, logic known, logic [63:0] kw);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if (sent % 50 < 10) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        hash_word(it, known, kw);
        sent++;
    endtask

    function automatic t_in_item rand_word(logic last);
        t_in_item it;
        it.message_word = {$urandom, $urandom};
        if ($urandom_range(0, 7) == 0) it.message_word = $urandom_range(0, 1) ? '1 : '0;
        it.valid_bytes = last ? (($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                                             : 4'($urandom_range(0, 8)))
                              : 4'($urandom_range(0, 15));
        it.last_word = last;
        return it;
    endfunction

    t_vector vectors [$];

    initial begin
        t_vector v;
        int len;
        errors = 0;
        cycles = 0;
        sent = 0;
        sending = 1'b1;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data = '0;
        chain = H0;
        msg_bits = 0;
        slot = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty message
        v.item = '{64'd0, 4'd0, 1'b1}; v.known = 1; v.first_word = EmptyH0;
        vectors = {vectors, v};
        v.known = 0; v.first_word = '0;
        // garbage past valid_bytes ignored
        v.item = '{64'hffffffffffffffff, 4'd0, 1'b1}; v.known = 1; v.first_word = EmptyH0;
        vectors = {vectors, v};
        v.known = 0; v.first_word = '0;
        for (int n = 1; n <= 15; n++) begin
            v.item = '{64'hffffffffffffffff, 4'(n), 1'b1};
            vectors = {vectors, v};
        end
        // non-last word with odd valid_bytes, then last word
        v.item = '{64'h0123456789abcdef, 4'd3, 1'b0}; vectors = {vectors, v};
        v.item = '{64'hfedcba9876543210, 4'd5, 1'b1}; vectors = {vectors, v};
        // 15 words then a full last word: padding spills into a second block
        for (int i = 0; i < 15; i++) begin
            v.item = '{64'h0, 4'd8, 1'b0}; vectors = {vectors, v};
        end
        v.item = '{64'hffffffffffffffff, 4'd8, 1'b1}; vectors = {vectors, v};

        @(posedge i_clk);
        foreach (vectors[i]) send(vectors[i].item, vectors[i].known, vectors[i].first_word);
        i_valid <= 1'b0;

        // hold off until all digests are out
        sending = 1'b0;
        while (digest_q.size() != 0) @(posedge i_clk);
        sending = 1'b1;

        while (sent < 200) begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
            for (int i = 0; i < len; i++) send(rand_word(1'b0), 1'b0, '0);
            send(rand_word(1'b1), 1'b0, '0);
        end
        i_valid <= 1'b0;

        sending = 1'b0;
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/sha512_pkg.sv
rtl/sha512_message_hasher_unit.sv
test/sha512_message_hasher_unit_tb.sv
